[sv/lphs_pkg.sv]
package lphs_pkg;

   localparam int MAX_SLOTS  = 1024;
   localparam int SLOT_IDX_W = $clog2(MAX_SLOTS);
   localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
   localparam int KEY_W      = 31;
   localparam int OP_W       = 2;
   localparam int BUCKET_W   = 11;
   localparam int DIV_CNT_W  = $clog2(KEY_W);
   localparam int REQ_DATA_W = ((OP_W + KEY_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      TAG_EMPTY   = 2'd0,
      TAG_USED    = 2'd1,
      TAG_DELETED = 2'd2
   } slot_tag_type;

   typedef struct packed {
      slot_tag_type     tag;
      logic [KEY_W-1:0] key;
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_CHECK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic div_step;
      logic rd;
      logic advance;
      logic wr_insert;
      logic wr_delete;
      logic res_set;
      logic res_val;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic   clear_last;
      op_type op;
      logic   full;
      logic   div_last;
      logic   rd_empty;
      logic   rd_match;
      logic   tomb_avail;
      logic   chain_end;
      logic   out_free;
   } ctrl_status_type;

endpackage

[sv/lphs_ctrl.sv]
module lphs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  lphs_pkg::ctrl_status_type status,
   output lphs_pkg::ctrl_cmd_type    cmd
);
   import lphs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // drop unknown ops and inserts into a full set before hashing
            if (!(status.op inside {OP_INSERT, OP_SEARCH, OP_DELETE})
                || (status.op == OP_INSERT && status.full)) begin
               cmd.res_set = 1'b1;
               cmd.res_val = 1'b0;
               state_in    = ST_RESP;
            end else begin
               cmd.div_step = 1'b1;
               if (status.div_last) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.res_set = 1'b1;
            state_in    = ST_RESP;
            if (status.rd_empty) begin
               if (status.op == OP_INSERT) begin
                  cmd.wr_insert = 1'b1;
                  cmd.res_val   = 1'b1;
               end
            end else if (status.rd_match) begin
               case (status.op)
                  OP_SEARCH: cmd.res_val = 1'b1;
                  OP_DELETE: begin
                     cmd.wr_delete = 1'b1;
                     cmd.res_val   = 1'b1;
                  end
                  default: cmd.res_val = 1'b0;
               endcase
            end else begin
               cmd.advance = 1'b1;
               if (status.chain_end) begin
                  if (status.op == OP_INSERT && status.tomb_avail) begin
                     cmd.wr_insert = 1'b1;
                     cmd.res_val   = 1'b1;
                  end
               end else begin
                  cmd.res_set = 1'b0;
                  state_in    = ST_READ;
               end
            end
         end
         ST_RESP: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

[sv/lphs_datapath.sv]
module lphs_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lphs_pkg::ctrl_cmd_type              cmd,
   output lphs_pkg::ctrl_status_type           status,
   input  logic [lphs_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                csr_wr_en,
   input  logic [lphs_pkg::BUCKET_W-1:0]       csr_wr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lphs_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import lphs_pkg::*;

   slot_type mem [MAX_SLOTS];

   logic [BUCKET_W-1:0]   bucket_ff;
   op_type                op_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [KEY_W-1:0]      div_key_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [CNT_W-1:0]      n_ff;
   logic [CNT_W-1:0]      n_in;
   logic [CNT_W-1:0]      rem_ff;
   logic [CNT_W-1:0]      rem_in;
   logic [CNT_W:0]        trial;
   logic [SLOT_IDX_W-1:0] pos_ff;
   logic [SLOT_IDX_W-1:0] pos_in;
   logic [CNT_W-1:0]      pos_inc;
   logic [CNT_W-1:0]      steps_ff;
   logic                  have_tomb_ff;
   logic [SLOT_IDX_W-1:0] tomb_ff;
   logic [CNT_W-1:0]      live_ff;
   slot_type              rd_data_ff;
   logic                  res_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_success_ff;
   logic                  rd_tomb;
   logic                  mem_we;
   logic [SLOT_IDX_W-1:0] mem_waddr;
   slot_type              mem_wdata;

   // clamp the configured bucket count into 1..MAX_SLOTS
   always_comb begin
      if (bucket_ff == '0) begin
         n_in = CNT_W'(1);
      end else if (int'(bucket_ff) > MAX_SLOTS) begin
         n_in = CNT_W'(MAX_SLOTS);
      end else begin
         n_in = CNT_W'(bucket_ff);
      end
   end

   // one restoring step of key modulo n per cycle, top key bit first
   always_comb begin
      trial = {rem_ff, div_key_ff[KEY_W-1]};
      if (trial >= {1'b0, n_ff}) begin
         rem_in = CNT_W'(trial - {1'b0, n_ff});
      end else begin
         rem_in = CNT_W'(trial);
      end
   end

   // wrap at the bucket count
   always_comb begin
      pos_inc = CNT_W'(pos_ff) + CNT_W'(1);
      if (pos_inc == n_ff) begin
         pos_in = '0;
      end else begin
         pos_in = SLOT_IDX_W'(pos_inc);
      end
   end

   assign rd_tomb = (rd_data_ff.tag != TAG_USED) && (rd_data_ff.tag != TAG_EMPTY);

   always_comb begin
      mem_we    = cmd.clr_step | cmd.wr_insert | cmd.wr_delete;
      mem_waddr = pos_ff;
      mem_wdata = '{tag: TAG_EMPTY, key: '0};
      if (cmd.wr_insert) begin
         mem_waddr = have_tomb_ff ? tomb_ff : pos_ff;
         mem_wdata = '{tag: TAG_USED, key: key_ff};
      end else if (cmd.wr_delete) begin
         mem_wdata = '{tag: TAG_DELETED, key: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_ff <= BUCKET_W'(MAX_SLOTS);
      end else if (csr_wr_en) begin
         bucket_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= op_type'(req_tdata[OP_W-1:0]);
         key_ff     <= req_tdata[OP_W+KEY_W-1:OP_W];
         div_key_ff <= req_tdata[OP_W+KEY_W-1:OP_W];
         div_cnt_ff <= DIV_CNT_W'(KEY_W - 1);
         n_ff       <= n_in;
         rem_ff     <= '0;
      end else if (cmd.div_step) begin
         div_key_ff <= div_key_ff << 1;
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
         rem_ff     <= rem_in;
      end
      if (cmd.res_set) begin
         res_ff <= cmd.res_val;
      end
      if (cmd.rsp_load) begin
         rsp_success_ff <= res_ff;
      end
      if (cmd.advance && rd_tomb && !have_tomb_ff) begin
         tomb_ff <= pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         steps_ff     <= '0;
         have_tomb_ff <= 1'b0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            pos_ff <= pos_ff + SLOT_IDX_W'(1);
         end else if (cmd.div_step && div_cnt_ff == '0) begin
            // last step: the remainder is the home slot
            pos_ff       <= SLOT_IDX_W'(rem_in);
            steps_ff     <= '0;
            have_tomb_ff <= 1'b0;
         end else if (cmd.advance) begin
            pos_ff   <= pos_in;
            steps_ff <= steps_ff + CNT_W'(1);
            if (rd_tomb) begin
               have_tomb_ff <= 1'b1;
            end
         end
         if (cmd.wr_insert) begin
            live_ff <= live_ff + CNT_W'(1);
         end else if (cmd.wr_delete && live_ff != '0) begin
            live_ff <= live_ff - CNT_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.clear_last = (pos_ff == SLOT_IDX_W'(MAX_SLOTS - 1));
      status.op         = op_ff;
      status.full       = (live_ff >= n_ff);
      status.div_last   = (div_cnt_ff == '0);
      status.rd_empty   = (rd_data_ff.tag == TAG_EMPTY);
      status.rd_match   = (rd_data_ff.tag == TAG_USED) && (rd_data_ff.key == key_ff);
      status.tomb_avail = have_tomb_ff | rd_tomb;
      status.chain_end  = (steps_ff + CNT_W'(1) == n_ff);
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, rsp_success_ff};

endmodule

[sv/linear_probe_hash_set_top.sv]
// Hash set of 31-bit keys held in a 1024-slot store with linear probing.
// Request words arrive on the req_ stream: op (0 insert, 1 search, 2 delete)
// and key. Each request returns one word on the rsp_ stream whose low bit is
// the success flag. csr_wr_en/csr_wr_data set the bucket count (home slot is
// key modulo this count); write it only while no request is in flight.
// Each request steps through: take the word, the bit-serial key modulo
// bucket count (one step per key bit), then per slot visited on the probe
// chain one registered read of the slot store and one check, then loading
// the response register. Unknown ops and inserts into a full set skip the
// hashing and the probe and go straight to the response.
// One request is worked on at a time; the next request word is taken as soon
// as the response is loaded, even while that response still waits.
// If the receiver stalls, the response holds in its register and the next
// request stops before its own response is loaded.
// After reset the block sweeps the slot store to empty, one slot per cycle,
// and req_tready stays low until the sweep ends. The bucket
// count resets to 1024 and the key count to zero.
module linear_probe_hash_set_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lphs_pkg::REQ_DATA_W-1:0]     req_tdata,  // op[1:0], key[32:2], zeros
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lphs_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // success[0], zeros
   input  logic                                csr_wr_en,
   input  logic [lphs_pkg::BUCKET_W-1:0]       csr_wr_data
);
   import lphs_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   lphs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lphs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

[dv/linear_probe_hash_set_top_tb.sv]
module linear_probe_hash_set_top_tb;
   import lphs_pkg::*;

   localparam int          CYCLE_LIMIT  = 8_000_000;
   localparam int          PHASE_ITEMS  = 60;
   localparam int          HOLD_AFTER   = 150;
   localparam int          HOLD_CYCLES  = 600;
   localparam int          POOL_DEPTH   = 48;
   localparam logic [OP_W-1:0]  OP_UNKNOWN = 2'd3;
   localparam logic [KEY_W-1:0] KEY_MAX    = '1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [OP_W-1:0]  op;
   } hash_request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [BUCKET_W-1:0]   csr_wr_data = '0;

   // shadow copy of the slot store, key count and bucket register
   slot_tag_type        slot_tag_mem [MAX_SLOTS];
   logic [KEY_W-1:0]    slot_key_mem [MAX_SLOTS];
   logic [CNT_W-1:0]    keys_held = '0;
   logic [BUCKET_W-1:0] bucket_reg = BUCKET_W'(MAX_SLOTS);

   hash_request_type pend_q[$];
   bit               success_due_q[$];
   logic [KEY_W-1:0] key_pool[$];
   hash_request_type offered;
   bit               steady = 1'b0;
   int               errors = 0;
   int               words_seen = 0;
   int               hold_left = 0;
   bit               hold_done = 1'b0;
   int               cycle_count = 0;

   linear_probe_hash_set_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic int unsigned live_buckets();
      if (bucket_reg == '0) return 1;
      if (bucket_reg > BUCKET_W'(MAX_SLOTS)) return MAX_SLOTS;
      return 32'(bucket_reg);
   endfunction

   // Walk the probe chain once and apply the request to the shadow store.
   function automatic bit apply_request(hash_request_type r);
      int unsigned n, pos, steps, hit, tomb;
      bit          found, have_tomb, have_empty, stop, ok;
      n = live_buckets();
      pos = r.key % n;
      steps = 0;
      hit = 0;
      tomb = 0;
      found = 1'b0;
      have_tomb = 1'b0;
      have_empty = 1'b0;
      stop = 1'b0;
      ok = 1'b0;
      while (!stop && steps < n) begin
         if (slot_tag_mem[SLOT_IDX_W'(pos)] == TAG_EMPTY) begin
            have_empty = 1'b1;
            stop = 1'b1;
         end else if (slot_tag_mem[SLOT_IDX_W'(pos)] == TAG_USED
                      && slot_key_mem[SLOT_IDX_W'(pos)] == r.key) begin
            found = 1'b1;
            hit = pos;
            stop = 1'b1;
         end else begin
            if (slot_tag_mem[SLOT_IDX_W'(pos)] != TAG_USED && !have_tomb) begin
               have_tomb = 1'b1;
               tomb = pos;
            end
            pos = (pos + 1 == n) ? 0 : pos + 1;
            steps++;
         end
      end
      case (r.op)
         OP_INSERT: begin
            if (32'(keys_held) < n && !found && (have_tomb || have_empty)) begin
               if (have_tomb) pos = tomb;
               slot_tag_mem[SLOT_IDX_W'(pos)] = TAG_USED;
               slot_key_mem[SLOT_IDX_W'(pos)] = r.key;
               keys_held = keys_held + CNT_W'(1);
               ok = 1'b1;
            end
         end
         OP_SEARCH: ok = found;
         OP_DELETE: begin
            if (found) begin
               slot_tag_mem[SLOT_IDX_W'(hit)] = TAG_DELETED;
               slot_key_mem[SLOT_IDX_W'(hit)] = '0;
               if (keys_held != '0) keys_held = keys_held - CNT_W'(1);
               ok = 1'b1;
            end
         end
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic hash_request_type next_request(int unsigned n);
      hash_request_type r;
      int unsigned      pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      r.op = OP_INSERT;
      else if (pick < 70) r.op = OP_SEARCH;
      else if (pick < 97) r.op = OP_DELETE;
      else                r.op = OP_UNKNOWN;
      pick = $urandom_range(0, 99);
      if (pick < 35 && key_pool.size() != 0) begin
         r.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else if (pick < 60) begin
         // crowd a few home slots to build long chains
         r.key = KEY_W'($urandom_range(0, 5) * n + $urandom_range(0, 2));
      end else if (pick < 85) begin
         r.key = KEY_W'($urandom());
      end else begin
         case ($urandom_range(0, 2))
            0:       r.key = '0;
            1:       r.key = KEY_MAX;
            default: r.key = KEY_MAX - KEY_W'($urandom_range(0, 2 * n));
         endcase
      end
      if (r.op == OP_INSERT) begin
         key_pool.push_back(r.key);
         if (key_pool.size() > POOL_DEPTH) key_pool.delete(0);
      end
      return r;
   endfunction

   task automatic queue_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
      hash_request_type r;
      r.op = op;
      r.key = key;
      pend_q.push_back(r);
   endtask

   // Hold off until every queued word went in and every response came back.
   task automatic drain();
      while (pend_q.size() != 0 || success_due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_buckets(logic [BUCKET_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      bucket_reg = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            success_due_q.push_back(apply_request(offered));
            pend_q.delete(0);
         end
         if (!req_tvalid || req_tready) begin
            if (pend_q.size() != 0 && (steady || $urandom_range(0, 99) >= 37)) begin
               offered = pend_q[0];
               req_tvalid <= 1'b1;
               req_tdata <= {{(REQ_DATA_W - KEY_W - OP_W){1'b0}}, pend_q[0].key, pend_q[0].op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver
   always @(posedge clock) begin
      bit want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            if (success_due_q.size() == 0) begin
               $display("%0t: response word with none expected: expected none actual %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = success_due_q.pop_front();
               if (rsp_tdata !== {{(RSP_DATA_W - 1){1'b0}}, want}) begin
                  $display("%0t: success mismatch: expected %h actual %h", $time,
                           {{(RSP_DATA_W - 1){1'b0}}, want}, rsp_tdata);
                  errors++;
               end
            end
         end
         // one long stall so the block backs up into the request side
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!hold_done && words_seen >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 37);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT + MAX_SLOTS) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned bucket_plan [12] = '{1, 2047, 2, 7, 16, 0, 61, 1024, 3, 128, 1000, 33};
      int unsigned n;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         slot_tag_mem[SLOT_IDX_W'(i)] = TAG_EMPTY;
         slot_key_mem[SLOT_IDX_W'(i)] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: duplicates, a chain across a tombstone, key extremes, unknown op
      queue_request(OP_SEARCH, 31'd5);
      queue_request(OP_INSERT, 31'd0);
      queue_request(OP_INSERT, 31'd0);
      queue_request(OP_INSERT, 31'd1024);
      queue_request(OP_INSERT, 31'd1);
      queue_request(OP_DELETE, 31'd0);
      queue_request(OP_SEARCH, 31'd1024);
      queue_request(OP_INSERT, 31'd1024);
      queue_request(OP_INSERT, 31'd2048);
      queue_request(OP_DELETE, 31'd1);
      queue_request(OP_DELETE, 31'd1);
      queue_request(OP_INSERT, KEY_MAX);
      queue_request(OP_SEARCH, KEY_MAX);
      queue_request(OP_DELETE, KEY_MAX);
      queue_request(OP_UNKNOWN, 31'd7);
      queue_request(OP_SEARCH, 31'd2048);
      drain();
      // zero bucket count acts as one slot; keys beyond it stay put
      set_buckets('0);
      queue_request(OP_DELETE, 31'd2048);
      queue_request(OP_SEARCH, 31'd1024);
      queue_request(OP_INSERT, 31'd9);
      drain();

      for (int i = 0; i < 12; i++) begin
         set_buckets(BUCKET_W'(bucket_plan[i]));
         n = live_buckets();
         steady <= (i == 7);
         repeat (PHASE_ITEMS) pend_q.push_back(next_request(n));
         drain();
         steady <= 1'b0;
         // clear out the set before the count changes, except where keys should carry over
         if (i != 6 && i != 9) begin
            for (int s = 0; s < n; s++)
               if (slot_tag_mem[SLOT_IDX_W'(s)] == TAG_USED)
                  queue_request(OP_DELETE, slot_key_mem[SLOT_IDX_W'(s)]);
            drain();
         end
      end

      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
